// ===== rtl/core/mbs_pkg.sv =====
`default_nettype none
package mbs_pkg;

  localparam int MAX_BOUNDARY = 56;
  localparam int NUM_WORDS    = 7;
  localparam int PAT_LEN      = MAX_BOUNDARY + 4;
  localparam int LEN_W        = 6;
  localparam int OFF_W        = 32;

  localparam logic [2:0] REG_LENGTH = 3'(NUM_WORDS);

  localparam logic [7:0] CHAR_CR   = 8'h0d;
  localparam logic [7:0] CHAR_LF   = 8'h0a;
  localparam logic [7:0] CHAR_DASH = 8'h2d;

  localparam logic [OFF_W-1:0] OFF_MAX = '1;

  typedef logic [PAT_LEN-1:0][7:0] pat_t;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PART      = 3'd1,
    EV_CLOSE     = 3'd2,
    EV_MALFORMED = 3'd3,
    EV_END       = 3'd4
  } event_t;

  typedef enum logic [5:0] {
    PH_SEEK_FIRST = 6'b000001,
    PH_SEEK       = 6'b000010,
    PH_TAIL       = 6'b000100,
    PH_CLOSE_TAIL = 6'b001000,
    PH_CLOSED     = 6'b010000,
    PH_FAILED     = 6'b100000
  } phase_t;

  typedef struct packed {
    pat_t             pattern;
    logic [LEN_W-1:0] used_len;
  } cfg_t;

  typedef struct packed {
    logic [PAT_LEN-1:0] mv;
    logic               done;
    logic [LEN_W-1:0]   plen;
  } match_t;

endpackage
`default_nettype wire

// ===== rtl/core/mbs_cfg.sv =====
`default_nettype none
module mbs_cfg
  import mbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [63:0] cfg_wdata,
  output cfg_t             cfg
);

  logic [63:0]      word_r [NUM_WORDS];
  logic [LEN_W-1:0] len_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < NUM_WORDS; w++) word_r[w] <= '0;
      len_r <= LEN_W'(1);
    end else if (cfg_we) begin
      if (cfg_index == REG_LENGTH) begin
        len_r <= cfg_wdata[LEN_W-1:0];
      end else begin
        word_r[cfg_index] <= cfg_wdata;
      end
    end
  end

  always_comb begin
    cfg.pattern    = '0;
    cfg.pattern[0] = CHAR_CR;
    cfg.pattern[1] = CHAR_LF;
    cfg.pattern[2] = CHAR_DASH;
    cfg.pattern[3] = CHAR_DASH;
    for (int w = 0; w < NUM_WORDS; w++) begin
      for (int j = 0; j < 8; j++) begin
        cfg.pattern[4 + 8*w + j] = word_r[w][8*j +: 8];
      end
    end
    // clamp length into 1..MAX_BOUNDARY
    if (len_r == '0) begin
      cfg.used_len = LEN_W'(1);
    end else if (len_r > LEN_W'(MAX_BOUNDARY)) begin
      cfg.used_len = LEN_W'(MAX_BOUNDARY);
    end else begin
      cfg.used_len = len_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/mbs_match.sv =====
`default_nettype none
module mbs_match
  import mbs_pkg::*;
(
  input  wire cfg_t                cfg,
  input  wire logic [7:0]          data_byte,
  input  wire logic                first,
  input  wire logic [PAT_LEN-1:0]  mv_cur,
  output match_t                   res
);

  logic [PAT_LEN-1:0] eq;
  logic [PAT_LEN-1:0] hits;
  logic [PAT_LEN-1:0] mask;
  logic [PAT_LEN-1:0] eq_sh;
  logic [LEN_W-1:0]   plen;
  logic [LEN_W-1:0]   top_bit;

  always_comb begin
    for (int i = 0; i < PAT_LEN; i++) eq[i] = (cfg.pattern[i] == data_byte);
    // the first delimiter has no leading CR LF
    eq_sh = {2'b00, eq[PAT_LEN-1:2]};
    plen  = first ? (cfg.used_len + LEN_W'(2)) : (cfg.used_len + LEN_W'(4));
    for (int i = 0; i < PAT_LEN; i++) mask[i] = (LEN_W'(i) < plen);
    hits    = (first ? eq_sh : eq) & mask;
    top_bit = plen - LEN_W'(1);
    res.mv   = {mv_cur[PAT_LEN-2:0], 1'b1} & hits;
    res.done = res.mv[top_bit];
    res.plen = plen;
  end

endmodule
`default_nettype wire

// ===== rtl/core/mbs_track.sv =====
`default_nettype none
module mbs_track
  import mbs_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               advance,
  input  wire logic [7:0]         data_byte,
  input  wire logic               last,
  input  wire match_t             match,
  output logic                    first,
  output logic [PAT_LEN-1:0]      mv,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [2:0]              out_event_res,
  output logic [OFF_W-1:0]        out_data_end,
  output logic [OFF_W-1:0]        out_part_start
);

  phase_t             phase_r, phase_nxt;
  logic [PAT_LEN-1:0] mv_r, mv_nxt;
  logic               tail_seen_r, tail_seen_nxt;
  logic [7:0]         first_tail_r, first_tail_nxt;
  logic [OFF_W-1:0]   offset_r, offset_nxt;
  logic [OFF_W-1:0]   delim_r, delim_nxt;
  logic               out_valid_r;
  event_t             ev_r, ev;
  logic [OFF_W-1:0]   de_r, de;
  logic [OFF_W-1:0]   ps_r, ps;
  logic [OFF_W-1:0]   off_inc;
  logic [OFF_W:0]     end_pos;

  assign first          = (phase_r == PH_SEEK_FIRST);
  assign mv             = mv_r;
  assign out_valid      = out_valid_r;
  assign out_event_res  = ev_r;
  assign out_data_end   = de_r;
  assign out_part_start = ps_r;

  always_comb begin
    off_inc        = (offset_r == OFF_MAX) ? OFF_MAX : offset_r + OFF_W'(1);
    end_pos        = {1'b0, offset_r} + (OFF_W+1)'(1);
    phase_nxt      = phase_r;
    mv_nxt         = mv_r;
    tail_seen_nxt  = tail_seen_r;
    first_tail_nxt = first_tail_r;
    delim_nxt      = delim_r;
    offset_nxt     = off_inc;
    ev             = EV_NONE;
    de             = '0;
    ps             = '0;
    case (phase_r)
      PH_SEEK_FIRST, PH_SEEK: begin
        mv_nxt = match.mv;
        if (match.done) begin
          if (end_pos >= (OFF_W+1)'(match.plen)) begin
            delim_nxt = OFF_W'(end_pos - (OFF_W+1)'(match.plen));
          end else begin
            delim_nxt = '0;
          end
          mv_nxt        = '0;
          phase_nxt     = PH_TAIL;
          tail_seen_nxt = 1'b0;
        end
      end
      PH_TAIL: begin
        if (!tail_seen_r) begin
          first_tail_nxt = data_byte;
          tail_seen_nxt  = 1'b1;
        end else if (first_tail_r == CHAR_DASH && data_byte == CHAR_DASH) begin
          phase_nxt     = PH_CLOSE_TAIL;
          tail_seen_nxt = 1'b0;
        end else begin
          if (first_tail_r == CHAR_CR && data_byte == CHAR_LF) begin
            ev        = EV_PART;
            phase_nxt = PH_SEEK;
          end else begin
            ev        = EV_MALFORMED;
            phase_nxt = PH_FAILED;
          end
          de            = delim_r;
          ps            = off_inc;
          tail_seen_nxt = 1'b0;
          mv_nxt        = '0;
        end
      end
      PH_CLOSE_TAIL: begin
        // two bytes after the closing dashes, not checked
        if (!tail_seen_r) begin
          tail_seen_nxt = 1'b1;
        end else begin
          ev            = EV_CLOSE;
          de            = delim_r;
          ps            = off_inc;
          phase_nxt     = PH_CLOSED;
          tail_seen_nxt = 1'b0;
        end
      end
      PH_CLOSED, PH_FAILED: begin
      end
      default: begin
        phase_nxt = PH_SEEK_FIRST;
      end
    endcase
    if (last) begin
      if (phase_nxt != PH_CLOSED && phase_nxt != PH_FAILED) begin
        ev = EV_END;
        de = off_inc;
        ps = off_inc;
      end
      phase_nxt      = PH_SEEK_FIRST;
      mv_nxt         = '0;
      tail_seen_nxt  = 1'b0;
      first_tail_nxt = '0;
      offset_nxt     = '0;
      delim_nxt      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_SEEK_FIRST;
      mv_r         <= '0;
      tail_seen_r  <= 1'b0;
      first_tail_r <= '0;
      offset_r     <= '0;
      delim_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (advance) begin
        phase_r      <= phase_nxt;
        mv_r         <= mv_nxt;
        tail_seen_r  <= tail_seen_nxt;
        first_tail_r <= first_tail_nxt;
        offset_r     <= offset_nxt;
        delim_r      <= delim_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      ev_r <= ev;
      de_r <= de;
      ps_r <= ps;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/multipart_boundary_scanner.sv =====
// Channel  Direction  Handshake               Payload
// in       input      in_valid / in_ready     in_data_byte, in_end_of_body
// out      output     out_valid / out_ready   out_event_res, out_data_end, out_part_start
// cfg      input      cfg_we                  cfg_index, cfg_wdata
//
// One item per cycle unless out stalls; an item passes the input, then the result register.
// The cycle is set by the shift-and match: 60 byte compares, a mask and a bit select.
// Reset (rst_n low, synchronous) clears the scan state and sets boundary length 1.
// A stall on out holds the result register; the input register keeps taking items
// until it is full too, and then in_ready drops.
`default_nettype none
module multipart_boundary_scanner
  import mbs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        in_data_byte,
  input  wire logic              in_end_of_body,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [2:0]             out_event_res,
  output logic [OFF_W-1:0]       out_data_end,
  output logic [OFF_W-1:0]       out_part_start,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [63:0]       cfg_wdata
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_last_r;
  logic               advance;
  logic               first;
  logic [PAT_LEN-1:0] mv;
  cfg_t               cfg;
  match_t             match;

  assign advance  = s1_valid_r && (!out_valid || out_ready);
  assign in_ready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_byte_r <= in_data_byte;
      s1_last_r <= in_end_of_body;
    end
  end

  mbs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mbs_match u_match (
    .cfg       (cfg),
    .data_byte (s1_byte_r),
    .first     (first),
    .mv_cur    (mv),
    .res       (match)
  );

  mbs_track u_track (
    .clk            (clk),
    .rst_n          (rst_n),
    .advance        (advance),
    .data_byte      (s1_byte_r),
    .last           (s1_last_r),
    .match          (match),
    .first          (first),
    .mv             (mv),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_event_res  (out_event_res),
    .out_data_end   (out_data_end),
    .out_part_start (out_part_start)
  );

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result register empty");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_NONE |-> out_data_end == '0 && out_part_start == '0)
    else $error("offsets reported without an event");

  a_end_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res == EV_END |-> out_data_end == out_part_start)
    else $error("unexpected end offsets differ");

  a_event_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_event_res <= EV_END)
    else $error("event code out of range");

endmodule
`default_nettype wire
